// ----- src/sssp_pkg.sv -----
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants for the shortest path block
// Field widths, command codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sssp_pkg;

   localparam int VERTEX_COUNT_DEFAULT  = 16;
   localparam int NO_EDGE_VALUE_DEFAULT = 65535;

   localparam int DIST_WIDTH      = 16;
   localparam int PRED_WIDTH      = 4;
   localparam int VERT_WIDTH      = 4;
   localparam int MAX_RESULTS     = 16;
   localparam int REQ_TDATA_WIDTH = 32;
   localparam int RSP_TDATA_WIDTH = 24;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_RUN   = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_RELAX = 2'd1,
      KIND_EMIT  = 2'd2
   } sweep_kind_type;

   typedef struct packed {
      logic           edge_write;
      logic           src_load;
      logic           rd_en;
      sweep_kind_type kind;
      logic           track_clear;
      logic           pick_latch;
      logic           out_load;
      logic           out_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic src_ok;
      logic edge_ok;
      logic found;
      logic busy;
   } ctrl_status_type;

endpackage

// ----- src/sssp_datapath.sv -----
// ----------------------------------------------------------------------------
// sssp_datapath: weight matrix, distance tables and relaxation arithmetic
// One memory read stage, then a write-back stage that relaxes one vertex and
// tracks the nearest unfinished vertex for the next round.
// ----------------------------------------------------------------------------
module sssp_datapath #(
   parameter int VERTEX_COUNT  = sssp_pkg::VERTEX_COUNT_DEFAULT,
   parameter int NO_EDGE_VALUE = sssp_pkg::NO_EDGE_VALUE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sssp_pkg::ctrl_cmd_type                 cmd,
   input  logic [$clog2(VERTEX_COUNT)-1:0]        index,
   output sssp_pkg::ctrl_status_type              status,
   input  logic [sssp_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [sssp_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   output logic                                   rsp_tlast
);
   import sssp_pkg::*;

   localparam int VW = $clog2(VERTEX_COUNT);
   localparam int MW = $clog2(VERTEX_COUNT * VERTEX_COUNT);
   localparam logic [DIST_WIDTH-1:0] NO_EDGE = DIST_WIDTH'(NO_EDGE_VALUE);

   logic [VERT_WIDTH-1:0] req_from;
   logic [VERT_WIDTH-1:0] req_to;
   logic [DIST_WIDTH-1:0] req_weight;
   logic [VERT_WIDTH-1:0] req_src;

   assign req_from   = req_tdata[3:0];
   assign req_to     = req_tdata[7:4];
   assign req_weight = req_tdata[23:8];
   assign req_src    = req_tdata[27:24];

   logic [DIST_WIDTH-1:0] weight_mem [VERTEX_COUNT*VERTEX_COUNT];
   logic [DIST_WIDTH-1:0] dist_mem   [VERTEX_COUNT];
   logic [PRED_WIDTH-1:0] parent_mem [VERTEX_COUNT];
   logic                  done_mem   [VERTEX_COUNT];

   logic [DIST_WIDTH-1:0] w_rd_ff, d_rd_ff;
   logic [PRED_WIDTH-1:0] p_rd_ff;
   logic                  f_rd_ff;

   logic [VW-1:0]          src_ff, pick_ff;
   logic [DIST_WIDTH-1:0]  near_ff;
   logic [DIST_WIDTH-1:0]  trk_best_ff, trk_best_in;
   logic [VW-1:0]          trk_idx_ff, trk_idx_in;
   logic                   trk_found_ff, trk_found_in;
   logic                   s1_vld_ff;
   logic [VW-1:0]          s1_idx_ff;
   sweep_kind_type         s1_kind_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VERT_WIDTH-1:0]  rsp_vertex_ff;
   logic [DIST_WIDTH-1:0]  rsp_dist_ff;
   logic [PRED_WIDTH-1:0]  rsp_pred_ff;
   logic                   rsp_last_ff;

   logic [VW-1:0]          row;
   logic [MW-1:0]          rd_addr, wr_addr;
   logic [DIST_WIDTH-1:0]  weight_sat;
   logic [DIST_WIDTH:0]    sum;
   logic [DIST_WIDTH-1:0]  cand;
   logic                   dist_we, done_we, done_wd, trk_ok;
   logic [DIST_WIDTH-1:0]  dist_wd, trk_val;
   logic [PRED_WIDTH-1:0]  par_wd;

   assign status.src_ok  = 32'(req_src) < VERTEX_COUNT;
   assign status.edge_ok = (32'(req_from) < VERTEX_COUNT) && (32'(req_to) < VERTEX_COUNT);
   assign status.found   = trk_found_ff;
   assign status.busy    = rsp_valid_ff && !rsp_tready;

   assign row        = (cmd.kind == KIND_INIT) ? src_ff : pick_ff;
   assign rd_addr    = MW'(MW'(row) * MW'(VERTEX_COUNT) + MW'(index));
   assign wr_addr    = MW'(MW'(VW'(req_from)) * MW'(VERTEX_COUNT) + MW'(VW'(req_to)));
   assign weight_sat = (req_weight > NO_EDGE) ? NO_EDGE : req_weight;

   assign sum  = {1'b0, near_ff} + {1'b0, w_rd_ff};
   assign cand = (w_rd_ff == NO_EDGE)        ? NO_EDGE :
                 (sum > {1'b0, NO_EDGE})     ? NO_EDGE : sum[DIST_WIDTH-1:0];

   always_comb begin
      dist_we = 1'b0;
      done_we = 1'b0;
      done_wd = 1'b0;
      dist_wd = w_rd_ff;
      par_wd  = '0;
      trk_ok  = 1'b0;
      trk_val = d_rd_ff;
      if (s1_vld_ff) begin
         if (s1_kind_ff == KIND_INIT) begin
            dist_we = 1'b1;
            done_we = 1'b1;
            if (s1_idx_ff == src_ff) begin
               dist_wd = '0;
               done_wd = 1'b1;
            end else begin
               trk_ok  = 1'b1;
               trk_val = w_rd_ff;
            end
         end else if (s1_idx_ff == pick_ff) begin
            done_we = 1'b1;
            done_wd = 1'b1;
         end else if (!f_rd_ff) begin
            trk_ok = 1'b1;
            if (cand < d_rd_ff) begin
               dist_we = 1'b1;
               dist_wd = cand;
               par_wd  = PRED_WIDTH'(pick_ff);
               trk_val = cand;
            end
         end
      end
   end

   always_comb begin
      trk_best_in  = trk_best_ff;
      trk_idx_in   = trk_idx_ff;
      trk_found_in = trk_found_ff;
      if (cmd.track_clear) begin
         trk_best_in  = NO_EDGE;
         trk_idx_in   = '0;
         trk_found_in = 1'b0;
      end else if (trk_ok && (trk_val < trk_best_ff)) begin
         trk_best_in  = trk_val;
         trk_idx_in   = s1_idx_ff;
         trk_found_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_write) begin
         weight_mem[wr_addr] <= weight_sat;
      end
      if (cmd.rd_en) begin
         w_rd_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[s1_idx_ff]   <= dist_wd;
         parent_mem[s1_idx_ff] <= par_wd;
      end
      if (done_we) begin
         done_mem[s1_idx_ff] <= done_wd;
      end
      if (cmd.rd_en) begin
         d_rd_ff <= dist_mem[index];
         p_rd_ff <= parent_mem[index];
         f_rd_ff <= done_mem[index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         trk_found_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= cmd.rd_en && (cmd.kind != KIND_EMIT);
         rsp_valid_ff <= rsp_valid_in;
         trk_found_ff <= trk_found_in;
      end
   end

   always_ff @(posedge clock) begin
      trk_best_ff <= trk_best_in;
      trk_idx_ff  <= trk_idx_in;
      if (cmd.rd_en) begin
         s1_idx_ff  <= index;
         s1_kind_ff <= cmd.kind;
      end
      if (cmd.src_load) begin
         src_ff <= VW'(req_src);
      end
      if (cmd.pick_latch) begin
         pick_ff <= trk_idx_ff;
         near_ff <= trk_best_ff;
      end
      if (cmd.out_load) begin
         rsp_vertex_ff <= VERT_WIDTH'(s1_idx_ff);
         rsp_dist_ff   <= d_rd_ff;
         rsp_pred_ff   <= p_rd_ff;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pred_ff, rsp_dist_ff, rsp_vertex_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/sssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// sssp_ctrl: sequencer for edge writes, relaxation sweeps and result output
// Steps a vertex counter through each sweep and counts relaxation rounds.
// ----------------------------------------------------------------------------
module sssp_ctrl #(
   parameter int VERTEX_COUNT = sssp_pkg::VERTEX_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,
   input  sssp_pkg::ctrl_status_type        status,
   output sssp_pkg::ctrl_cmd_type           cmd,
   output logic [$clog2(VERTEX_COUNT)-1:0]  index
);
   import sssp_pkg::*;

   localparam int VW = $clog2(VERTEX_COUNT);
   localparam int CW = $clog2(VERTEX_COUNT + 2);
   localparam int EMIT_COUNT = (VERTEX_COUNT < MAX_RESULTS) ? VERTEX_COUNT : MAX_RESULTS;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_INIT    = 5'b00010,
      ST_RELAX   = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT_LD = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] round_ff, round_in;
   logic          accept;
   logic          emit_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign index      = cnt_ff[VW-1:0];
   assign emit_last  = (cnt_ff == CW'(EMIT_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      round_in = round_ff;
      cmd      = '0;
      cmd.kind = KIND_INIT;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (command_type'(req_tuser) == CMD_RUN) begin
                  if (status.src_ok) begin
                     cmd.src_load    = 1'b1;
                     cmd.track_clear = 1'b1;
                     cnt_in          = '0;
                     round_in        = '0;
                     state_in        = ST_INIT;
                  end
               end else begin
                  cmd.edge_write = status.edge_ok;
               end
            end
         end
         ST_INIT, ST_RELAX: begin
            cmd.kind = (state_ff == ST_INIT) ? KIND_INIT : KIND_RELAX;
            cmd.rd_en = (cnt_ff < CW'(VERTEX_COUNT));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(VERTEX_COUNT + 1)) begin
               cmd.pick_latch  = 1'b1;
               cmd.track_clear = 1'b1;
               cnt_in          = '0;
               if (status.found && (round_ff != VW'(VERTEX_COUNT - 1))) begin
                  round_in = round_ff + 1'b1;
                  state_in = ST_RELAX;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.kind  = KIND_EMIT;
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.kind = KIND_EMIT;
            if (!status.busy) begin
               cmd.out_load = 1'b1;
               cmd.out_last = emit_last;
               if (emit_last) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         round_ff <= round_in;
      end
   end

endmodule

// ----- src/single_source_shortest_path.sv -----
// ----------------------------------------------------------------------------
// single_source_shortest_path: Dijkstra over a stored adjacency matrix
// Input items either write one edge weight or run from a source vertex.
//
// req channel: tuser is the command (write or run), tdata holds the edge
// endpoints, the weight and the source. A write gives no result. A run gives
// one result item per vertex (at most sixteen), in vertex order, with tlast
// on the final one.
// A run sweeps the vertices once to load the source row, then does up to V-1
// relaxation sweeps, one vertex per cycle through the single matrix read
// port; the nearest unfinished vertex is found during the same sweep. It
// stops early when nothing reachable is left. Each result is read in
// ST_EMIT_RD and then loaded into the output register in ST_EMIT_LD.
// One item is worked on at a time: req_tready is high only while idle.
// The last result sits in an output register, so a new item may be accepted
// while it waits; a stalled rsp_tready holds the output sequence in place.
// Reset clears the control state; the weight matrix holds no value until
// written, and every row a run can reach must be written before that run.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
   parameter int VERTEX_COUNT  = sssp_pkg::VERTEX_COUNT_DEFAULT,
   parameter int NO_EDGE_VALUE = sssp_pkg::NO_EDGE_VALUE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // edge_from[3:0], edge_to[7:4], edge_weight[23:8], source_vertex[27:24]
   input  logic [sssp_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // command
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // vertex[3:0], distance[19:4], predecessor[23:20]
   output logic [sssp_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   output logic                                  rsp_tlast
);
   import sssp_pkg::*;

   ctrl_cmd_type                     cmd;
   ctrl_status_type                  status;
   logic [$clog2(VERTEX_COUNT)-1:0]  index;

   sssp_ctrl #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .index      (index)
   );

   sssp_datapath #(
      .VERTEX_COUNT  (VERTEX_COUNT),
      .NO_EDGE_VALUE (NO_EDGE_VALUE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .index      (index),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/tb_single_source_shortest_path.sv -----
// ----------------------------------------------------------------------------
// tb_single_source_shortest_path: self-checking bench for the shortest path block
// Fills the whole weight matrix, runs directed cases (unreachable vertices,
// zero and saturating weights), then random edge writes and runs. A scoreboard
// predicts the per-vertex distance/predecessor items and checks each one in
// order. Both stream sides idle at random; one long output stall is included.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_path;
   timeunit 1ns;
   timeprecision 1ps;

   import sssp_pkg::*;

   localparam int                    NUM_VERTS     = VERTEX_COUNT_DEFAULT;
   localparam logic [DIST_WIDTH-1:0] NO_EDGE       = DIST_WIDTH'(NO_EDGE_VALUE_DEFAULT);
   localparam int                    RANDOM_ITEMS  = 140;
   localparam int                    LONG_HOLD     = 600;
   localparam int                    DRAIN_CYCLES  = 400;

   typedef struct {
      logic [VERT_WIDTH-1:0] vertex;
      logic [DIST_WIDTH-1:0] distance;
      logic [PRED_WIDTH-1:0] predecessor;
      logic                  is_last;
   } path_result_type;

   class shortest_path_scoreboard_type;
      logic [DIST_WIDTH-1:0] weight_matrix [NUM_VERTS][NUM_VERTS];
      logic [DIST_WIDTH-1:0] best_dist [NUM_VERTS];
      logic [PRED_WIDTH-1:0] parent [NUM_VERTS];
      bit                    settled [NUM_VERTS];
      path_result_type       path_q [$];
      int                    mismatches;
      int                    checked;
      int                    writes;
      int                    runs;
      bit [NUM_VERTS-1:0]    sources_run;

      function int pending_count();
         return path_q.size();
      endfunction

      function void solve_from(int src);
         int near;
         int pick;
         int cand;
         bit found;
         for (int i = 0; i < NUM_VERTS; i++) begin
            settled[i]   = 0;
            parent[i]    = '0;
            best_dist[i] = weight_matrix[src][i];
         end
         settled[src]   = 1;
         best_dist[src] = '0;
         for (int round = 1; round < NUM_VERTS; round++) begin
            near  = int'(NO_EDGE);
            pick  = 0;
            found = 0;
            for (int j = 0; j < NUM_VERTS; j++) begin
               if (!settled[j] && int'(best_dist[j]) < near) begin
                  near  = int'(best_dist[j]);
                  pick  = j;
                  found = 1;
               end
            end
            if (!found) break;
            settled[pick] = 1;
            for (int j = 0; j < NUM_VERTS; j++) begin
               if (weight_matrix[pick][j] == NO_EDGE) cand = int'(NO_EDGE);
               else cand = near + int'(weight_matrix[pick][j]);
               if (cand > int'(NO_EDGE)) cand = int'(NO_EDGE);
               if (!settled[j] && cand < int'(best_dist[j])) begin
                  best_dist[j] = DIST_WIDTH'(cand);
                  parent[j]    = PRED_WIDTH'(pick);
               end
            end
         end
      endfunction

      function void note_item(command_type cmd, logic [VERT_WIDTH-1:0] from_v,
                              logic [VERT_WIDTH-1:0] to_v, logic [DIST_WIDTH-1:0] w,
                              logic [VERT_WIDTH-1:0] src);
         path_result_type r;
         if (cmd == CMD_WRITE) begin
            weight_matrix[from_v][to_v] = w;
            writes++;
            return;
         end
         runs++;
         sources_run[src] = 1;
         solve_from(int'(src));
         for (int v = 0; v < NUM_VERTS; v++) begin
            r.vertex      = VERT_WIDTH'(v);
            r.distance    = best_dist[v];
            r.predecessor = parent[v];
            r.is_last     = (v == NUM_VERTS - 1);
            path_q.push_back(r);
         end
      endfunction

      function void check_result(logic [RSP_TDATA_WIDTH-1:0] data, logic is_last);
         path_result_type e;
         if (path_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result tdata=%h tlast=%b", $realtime, data, is_last);
            return;
         end
         e = path_q.pop_front();
         checked++;
         if (data[3:0] !== e.vertex || data[19:4] !== e.distance ||
             data[23:20] !== e.predecessor || is_last !== e.is_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp v=%0d d=%0d p=%0d l=%b got v=%0d d=%0d p=%0d l=%b",
                        $realtime, e.vertex, e.distance, e.predecessor, e.is_last,
                        data[3:0], data[19:4], data[23:20], is_last);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tlast;

   shortest_path_scoreboard_type sb = new;
   int req_gap_max;
   int rsp_gap_max;
   bit long_hold_request;

   single_source_shortest_path i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Called right after a rising edge; returns right after the accepting edge.
   task automatic send_item(command_type cmd, logic [VERT_WIDTH-1:0] from_v,
                            logic [VERT_WIDTH-1:0] to_v, logic [DIST_WIDTH-1:0] w,
                            logic [VERT_WIDTH-1:0] src);
      int gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, src, w, to_v, from_v};
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, from_v, to_v, w, src);
   endtask

   task automatic write_edge(int from_v, int to_v, logic [DIST_WIDTH-1:0] w);
      send_item(CMD_WRITE, VERT_WIDTH'(from_v), VERT_WIDTH'(to_v), w,
                VERT_WIDTH'($urandom_range(0, 15)));
   endtask

   task automatic run_from(int src);
      send_item(CMD_RUN, VERT_WIDTH'($urandom_range(0, 15)),
                VERT_WIDTH'($urandom_range(0, 15)),
                DIST_WIDTH'($urandom_range(0, 65535)), VERT_WIDTH'(src));
   endtask

   function automatic logic [DIST_WIDTH-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 19);
      if (r < 6) return NO_EDGE;
      if (r < 8) return '0;
      if (r < 17) return DIST_WIDTH'($urandom_range(1, 60));
      return DIST_WIDTH'($urandom_range(0, 65535));
   endfunction

   // result side
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            gap = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_single_source_shortest_path: errors");
      $finish;
   end

   initial begin
      req_tvalid  = 1'b0;
      req_tuser   = CMD_WRITE;
      req_tdata   = '0;
      reset       = 1'b1;
      req_gap_max = 8;
      rsp_gap_max = 8;
      long_hold_request = 0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // every matrix entry gets a defined weight before any run
      for (int f = 0; f < NUM_VERTS; f++) begin
         if (f == 8) req_gap_max = 0;
         for (int t = 0; t < NUM_VERTS; t++)
            write_edge(f, t, pick_weight());
      end

      req_gap_max = 8;
      run_from(0);
      run_from(15);
      // isolated source: nothing reachable
      for (int t = 0; t < NUM_VERTS; t++)
         write_edge(9, t, NO_EDGE);
      run_from(9);
      write_edge(9, 4, '0);
      run_from(9);
      // near-max weight: onward sums saturate to no edge
      write_edge(9, 4, 16'hFFFE);
      long_hold_request = 1;
      run_from(9);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 35 == 0) begin
            case ((n / 35) % 4)
               0: begin req_gap_max = 0; rsp_gap_max = 0; end
               1: begin req_gap_max = 8; rsp_gap_max = 8; end
               2: begin req_gap_max = 0; rsp_gap_max = 8; end
               default: begin req_gap_max = 8; rsp_gap_max = 0; end
            endcase
         end
         if (n == RANDOM_ITEMS / 2) begin
            while (sb.pending_count() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 3) == 0) run_from($urandom_range(0, 15));
         else write_edge($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
      end

      @(negedge clock) req_tvalid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d edge writes and %0d runs (source mask %h); checked %0d vertex items.",
               sb.writes, sb.runs, sb.sources_run, sb.checked);
      $display("Included isolated, zero-weight and saturating sources, and a %0d-cycle stall.",
               LONG_HOLD);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("tb_single_source_shortest_path: clean");
      else
         $display("tb_single_source_shortest_path: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
src/sssp_pkg.sv
src/sssp_datapath.sv
src/sssp_ctrl.sv
src/single_source_shortest_path.sv
test/tb_single_source_shortest_path.sv
